/* design/lpf_pkg.sv */
// Package for the longest palindrome finder.
// Holds the channel payload types, the controller/datapath command and status
// structs, and the case-folding function. No dependencies.
package lpf_pkg;

	localparam int START_W = 10;
	localparam int LEN_W   = 11;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} in_t;

	typedef struct packed {
		logic [START_W-1:0] start_index;
		logic [LEN_W-1:0]   palin_length;
		logic               truncated;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // a string byte is accepted this cycle
		logic start;     // the accepted byte closes the string: arm the search
		logic init_ctr;  // place both read pointers on the current center
		logic step;      // move the pointers one byte outward
		logic close;     // finish the current center and move to the next
		logic publish;   // copy the best candidate into the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic match;        // the two bytes read compare equal
		logic at_edge;      // a pointer sits on either end of the string
		logic last_center;  // the center is the last byte of the string
		logic odd;          // the current center is an odd one
	} sts_t;

	// Only upper-case ASCII letters are folded; every other byte stays.
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

/* design/longest_palindrome_finder_unit.sv */
// Longest palindrome finder, top level.
// Joins the controller (lpf_ctrl) and the datapath (lpf_datapath); uses lpf_pkg.
//
// Usage:
//   The char channel (char_valid, char_stall, char_data) carries one string byte
//   per transaction; char_data.last_char marks the final byte. Bytes load one
//   per cycle. Bytes beyond MAX_LEN are dropped and the result's truncated bit
//   is set. Letters compare case-insensitively (ASCII A-Z folded to a-z).
//   After the last byte the block stalls the char channel and searches for the
//   longest palindromic substring by growing around every odd, then even, center.
//   Each center takes a setup step, then a memory read and a compare for each
//   pair examined, since both pointers share one two-read-port memory with
//   registered data. After the last center the result is moved into the
//   output register.
//   The result channel (result_valid, result_stall, result_data) carries one
//   transaction per string: start index, length (earliest on ties) and the
//   truncation flag. The result waits in its register while the receiver
//   stalls; loading of the next string goes on meanwhile, and only the hand-over
//   of the next result waits until the register is free.
//   Reset (arst_n low) empties the string and drops any pending result; the
//   memory itself is not cleared, as only bytes of the current string are read.
module longest_palindrome_finder_unit import lpf_pkg::*; #(
	parameter int MAX_LEN = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic char_valid,
	output logic char_stall,
	input  in_t  char_data,
	output logic result_valid,
	input  logic result_stall,
	output out_t result_data
);

	cmd_t cmd;
	sts_t sts;

	// The controller only ever sees status bits; all indexes stay in the datapath.
	lpf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.last_char    (char_data.last_char),
		.char_stall   (char_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	lpf_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_data   (char_data),
		.cmd         (cmd),
		.sts         (sts),
		.result_data (result_data)
	);

endmodule

/* design/lpf_datapath.sv */
// Datapath of the longest palindrome finder: string memory, byte count,
// center and pointer registers, best candidate and the result register.
// Depends on lpf_pkg.
module lpf_datapath import lpf_pkg::*; #(
	parameter int MAX_LEN = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  in_t  char_data,
	input  cmd_t cmd,
	output sts_t sts,
	output out_t result_data
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	logic [7:0]    mem [MAX_LEN];
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [AW-1:0] ctr_q;
	logic          odd_q;
	logic [AW-1:0] lo_q;
	logic [AW-1:0] hi_q;
	logic [7:0]    rd_lo_q;
	logic [7:0]    rd_hi_q;
	logic [AW-1:0] best_start_q;
	logic [CW-1:0] best_len_q;
	out_t          result_q;

	logic          has_room;
	logic [CW-1:0] lo_ext;
	logic [CW-1:0] hi_ext;
	logic [AW-1:0] cand_start;
	logic [CW-1:0] cand_len;

	assign has_room = count_q < CW'(MAX_LEN);
	assign lo_ext   = CW'(lo_q);
	assign hi_ext   = CW'(hi_q);

	always_comb begin
		sts.match       = fold_case(rd_lo_q) == fold_case(rd_hi_q);
		sts.at_edge     = (lo_q == '0) || (hi_ext + CW'(1) == count_q);
		sts.last_center = CW'(ctr_q) + CW'(1) == count_q;
		sts.odd         = odd_q;
	end

	// A matching pair that hits an end is part of the palindrome; a
	// mismatching pair bounds it from outside.
	always_comb begin
		if (sts.match) begin
			cand_start = lo_q;
			cand_len   = hi_ext - lo_ext + CW'(1);
		end else begin
			cand_start = lo_q + AW'(1);
			cand_len   = hi_ext - lo_ext - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			mem[count_q[AW-1:0]] <= char_data.char_in;
		end
		rd_lo_q <= mem[lo_q];
		rd_hi_q <= mem[hi_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.publish) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load) begin
			if (has_room) begin
				count_q <= count_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ctr_q        <= '0;
			odd_q        <= 1'b1;
			best_start_q <= '0;
			best_len_q   <= CW'(1);
		end
		if (cmd.init_ctr) begin
			lo_q <= ctr_q;
			hi_q <= odd_q ? ctr_q : ctr_q + AW'(1);
		end
		if (cmd.step) begin
			lo_q <= lo_q - AW'(1);
			hi_q <= hi_q + AW'(1);
		end
		if (cmd.close) begin
			if (cand_len > best_len_q) begin
				best_len_q   <= cand_len;
				best_start_q <= cand_start;
			end
			if (odd_q) begin
				odd_q <= 1'b0;
			end else begin
				odd_q <= 1'b1;
				ctr_q <= ctr_q + AW'(1);
			end
		end
		if (cmd.publish) begin
			result_q.start_index  <= START_W'(best_start_q);
			result_q.palin_length <= (count_q == '0) ? '0 : LEN_W'(best_len_q);
			result_q.truncated    <= ovf_q;
		end
	end

	assign result_data = result_q;

	overflow_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !has_room && !cmd.publish) |=> ovf_q)
		else $error("dropped byte did not set the truncation flag");

endmodule

/* design/lpf_ctrl.sv */
// Controller of the longest palindrome finder: sequences loading, the
// center-expansion search and the hand-over of the result.
// Depends on lpf_pkg.
module lpf_ctrl import lpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic char_valid,
	input  logic last_char,
	output logic char_stall,
	output logic result_valid,
	input  logic result_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		LOAD,
		INIT,
		READ,
		CMP,
		FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   result_valid_q;

	assign char_stall   = state_q != LOAD;
	assign result_valid = result_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			LOAD: begin
				cmd.load  = char_valid;
				cmd.start = char_valid && last_char;
				if (char_valid && last_char) begin
					state_d = INIT;
				end
			end
			INIT: begin
				cmd.init_ctr = 1'b1;
				state_d      = READ;
			end
			READ: begin
				state_d = CMP;
			end
			CMP: begin
				priority if (sts.match && !sts.at_edge) begin
					cmd.step = 1'b1;
					state_d  = READ;
				end else if (sts.odd && sts.last_center) begin
					cmd.close = 1'b1;
					state_d   = FINISH;
				end else begin
					cmd.close = 1'b1;
					state_d   = INIT;
				end
			end
			FINISH: begin
				if (!result_valid_q || !result_stall) begin
					cmd.publish = 1'b1;
					state_d     = LOAD;
				end
			end
			default: begin
				state_d = LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= LOAD;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	compare_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CMP) |-> ($past(state_q) == READ))
		else $error("compare without a preceding memory read");

	finish_after_last_center: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FINISH && $past(state_q) != FINISH) |->
		($past(sts.odd) && $past(sts.last_center)))
		else $error("search ended before the last center");

	result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> ($past(state_q) == FINISH))
		else $error("result raised outside the finish step");

endmodule

/* bench/lpf_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the longest palindrome finder: watches both channels,
// keeps its own copy of the string and predicts each result. Uses lpf_pkg.
module lpf_result_checker import lpf_pkg::*; #(
	parameter int MAX_LEN = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic char_valid,
	input  logic char_stall,
	input  in_t  char_data,
	input  logic result_valid,
	input  logic result_stall,
	input  out_t result_data,
	output int   fail_count,
	output int   outstanding
);

	logic [7:0] held_text [MAX_LEN];
	int         held_len;
	bit         dropped_any;
	int         fails;
	out_t       expected_spans [$];
	out_t       want;

	function automatic logic [7:0] lower_letter(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	// Grows around every odd center, then the even one beside it; only a
	// strictly longer span replaces the best, so the earliest wins a tie.
	function automatic out_t find_longest_span();
		int   lo;
		int   hi;
		int   span;
		int   best_start;
		int   best_span;
		out_t r;
		best_start = 0;
		best_span  = 0;
		for (int c = 0; c < held_len; c++) begin
			for (int w = 0; w < 2; w++) begin
				lo = c;
				hi = c + w;
				while (lo >= 0 && hi < held_len &&
				       lower_letter(held_text[lo]) == lower_letter(held_text[hi])) begin
					lo--;
					hi++;
				end
				span = (hi - 1) - (lo + 1);
				if (span > best_span) begin
					best_span  = span;
					best_start = lo + 1;
				end
			end
		end
		r.start_index  = best_start[START_W-1:0];
		r.palin_length = (held_len == 0) ? '0 : LEN_W'(best_span + 1);
		r.truncated    = dropped_any;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_len    = 0;
			dropped_any = 1'b0;
			fails       = 0;
			expected_spans.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_spans.size() == 0) begin
					$error({"result with no string pending: ",
					        "start_index %0d palin_length %0d truncated %0d"},
					       result_data.start_index, result_data.palin_length,
					       result_data.truncated);
					fails++;
				end else begin
					want = expected_spans.pop_front();
					if (result_data.start_index !== want.start_index) begin
						$error("start_index: expected %0d, actual %0d",
						       want.start_index, result_data.start_index);
						fails++;
					end
					if (result_data.palin_length !== want.palin_length) begin
						$error("palin_length: expected %0d, actual %0d",
						       want.palin_length, result_data.palin_length);
						fails++;
					end
					if (result_data.truncated !== want.truncated) begin
						$error("truncated: expected %0d, actual %0d",
						       want.truncated, result_data.truncated);
						fails++;
					end
				end
			end
			if (char_valid && !char_stall) begin
				if (held_len < MAX_LEN) begin
					held_text[held_len] = char_data.char_in;
					held_len++;
				end else begin
					dropped_any = 1'b1;
				end
				if (char_data.last_char) begin
					expected_spans = {expected_spans, find_longest_span()};
					held_len    = 0;
					dropped_any = 1'b0;
				end
			end
			fail_count  <= fails;
			outstanding <= expected_spans.size();
		end
	end

endmodule

/* bench/tb_longest_palindrome_finder_unit.sv */
`timescale 1ns / 1ps
// Testbench top for longest_palindrome_finder_unit: drives strings on the char
// channel, stalls the result channel and gives the verdict. Uses lpf_pkg and
// lpf_result_checker, which predicts and compares every result.
module tb_longest_palindrome_finder_unit;
	import lpf_pkg::*;

	localparam int MAX_LEN      = 1024;
	localparam int RANDOM_ITEMS = 300;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 64;

	logic clk          = 1'b0;
	logic arst_n       = 1'b0;
	logic char_valid   = 1'b0;
	logic char_stall;
	in_t  char_data    = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_t result_data;

	int fail_count;
	int outstanding;
	int cycle_count  = 0;
	int random_items = 0;

	// While set, neither side idles, so strings also run back to back.
	bit quiet_phase = 1'b0;

	// The string being built before it is sent.
	logic [7:0] text_q [$];

	longest_palindrome_finder_unit #(
		.MAX_LEN(MAX_LEN)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_data   (char_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data)
	);

	lpf_result_checker #(
		.MAX_LEN(MAX_LEN)
	) result_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_data   (char_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever begin
			#6 clk = ~clk;
		end
	end

	// A run that has not finished by the limit has hung somewhere.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Letters get a random case; the block must fold A-Z onto a-z when comparing.
	function automatic logic [7:0] vary_case(input logic [7:0] c);
		if (c >= 8'h61 && c <= 8'h7A) begin
			return $urandom_range(0, 1) ? c - 8'h20 : c;
		end
		if (c >= 8'h41 && c <= 8'h5A) begin
			return $urandom_range(0, 1) ? c + 8'h20 : c;
		end
		return c;
	endfunction

	// A small alphabet makes palindromes and ties frequent.
	function automatic logic [7:0] narrow_letter();
		return vary_case(8'h61 + 8'($urandom_range(0, 2)));
	endfunction

	// Any byte, with extra weight on the values just around the letter ranges,
	// where a sloppy case fold would go wrong.
	function automatic logic [7:0] any_byte();
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 7))
				0: return 8'h40;
				1: return 8'h41;
				2: return 8'h5A;
				3: return 8'h5B;
				4: return 8'h60;
				5: return 8'h61;
				6: return 8'h7A;
				default: return 8'h7B;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Offers one byte and holds it until the block takes it. After the
	// transaction the sender may go idle for a while; with no gap, valid simply
	// stays high for the next byte.
	task automatic send_char(input logic [7:0] b, input logic is_last);
		int gap;
		char_valid <= 1'b1;
		char_data  <= '{char_in: b, last_char: is_last};
		@(posedge clk);
		while (char_stall) begin
			@(posedge clk);
		end
		gap = quiet_phase ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sends the built string, marking its final byte, and clears it.
	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++) begin
			send_char(text_q[i], i == text_q.size() - 1);
		end
		text_q.delete();
	endtask

	// Random strings. Half are palindromes buried in short random text, so the
	// search has real work to do; the rest are plain noise, small-alphabet text
	// and runs of one letter, which make every center grow.
	task automatic build_random_text();
		logic [7:0] half [$];
		int         kind;
		int         h;
		logic [7:0] c;
		kind = $urandom_range(0, 19);
		if (kind < 3) begin
			repeat ($urandom_range(1, 12)) text_q = {text_q, any_byte()};
		end else if (kind < 8) begin
			repeat ($urandom_range(1, 16)) text_q = {text_q, narrow_letter()};
		end else if (kind < 10) begin
			c = narrow_letter();
			repeat ($urandom_range(1, 40)) text_q = {text_q, vary_case(c)};
		end else begin
			repeat ($urandom_range(0, 5)) text_q = {text_q, narrow_letter()};
			h = $urandom_range(0, 6);
			repeat (h) half = {half, ($urandom_range(0, 3) == 0 ? any_byte() : narrow_letter())};
			foreach (half[i]) text_q = {text_q, vary_case(half[i])};
			if ($urandom_range(0, 1)) begin
				text_q = {text_q, any_byte()};
			end
			for (int i = h - 1; i >= 0; i--) begin
				text_q = {text_q, vary_case(half[i])};
			end
			repeat ($urandom_range(0, 5)) text_q = {text_q, narrow_letter()};
		end
		if (text_q.size() == 0) begin
			text_q = {text_q, any_byte()};
		end
	endtask

	// The receiver stalls for a random number of cycles, then waits with stall
	// low until a result is handed over, and draws again for the next one.
	initial begin
		int hold;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			hold = quiet_phase ? 0 : $urandom_range(0, 16);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) begin
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [7:0] half [$];

		// Reset is held from the start and released once, on a clock edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: a single byte, pairs that do and do not fold into
		// each other at the edges of the letter range, the byte extremes, an
		// even palindrome, and a tie that the earlier odd center must win.
		text_q = '{8'h61};
		send_text();
		text_q = '{8'h41, 8'h61};
		send_text();
		text_q = '{8'h40, 8'h60};
		send_text();
		text_q = '{8'h5B, 8'h7B};
		send_text();
		text_q = '{8'h5A, 8'h7A};
		send_text();
		text_q = '{8'h00, 8'hFF, 8'h00};
		send_text();
		text_q = '{8'h61, 8'h62, 8'h42, 8'h61};
		send_text();
		text_q = '{8'h61, 8'h62, 8'h61, 8'h62};
		send_text();
		text_q = '{8'hFF};
		send_text();

		// Full-size string: a palindrome that fills the whole buffer, giving the
		// longest possible length, then one byte too many. That extra byte is
		// the one marked last, so it is dropped and the result is truncated.
		repeat (MAX_LEN / 2) half = {half, any_byte()};
		foreach (half[i]) text_q = {text_q, vary_case(half[i])};
		for (int i = MAX_LEN / 2 - 1; i >= 0; i--) begin
			text_q = {text_q, vary_case(half[i])};
		end
		text_q = {text_q, any_byte()};
		send_text();

		// Random strings, with stretches where neither side idles.
		while (random_items < RANDOM_ITEMS) begin
			quiet_phase = ($urandom_range(0, 5) == 0);
			build_random_text();
			random_items += text_q.size();
			send_text();
		end
		quiet_phase = 1'b0;

		// Give the checker a moment to register the last string, then wait for
		// every result and a little longer for anything unexpected.
		repeat (2) @(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
